@@ hdl/rtkd_pkg.sv @@
// ----------------------------------------------------------------------------
// rtkd_pkg: shared types and constants for the rapid trigger key detector
// Event codes, register indexes, reset values and the grouped config and
// tracking state carried between the detector modules.
// ----------------------------------------------------------------------------
package rtkd_pkg;

	localparam int LEVEL_W   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 8;

	localparam logic [LEVEL_W-1:0] FULL_TRAVEL = 8'd255;
	localparam logic [LEVEL_W-1:0] ZERO_TRAVEL = 8'd0;

	// event codes on the result channel
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} key_event_t;

	// register indexes on the config channel
	localparam logic [CFG_IDX_W-1:0] REG_RAPID_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEVEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_RISE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FALL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_PRESS      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_RELEASE    = 3'd7;

	// register reset values
	localparam logic [LEVEL_W-1:0] RST_PRESS_LEVEL   = 8'd128;
	localparam logic [LEVEL_W-1:0] RST_RELEASE_LEVEL = 8'd100;
	localparam logic [LEVEL_W-1:0] RST_PRESS_RISE    = 8'd16;
	localparam logic [LEVEL_W-1:0] RST_RELEASE_FALL  = 8'd16;
	localparam logic [LEVEL_W-1:0] RST_HOLD          = 8'd0;

	typedef struct packed {
		logic               rapid_mode;
		logic               continuous_mode;
		logic [LEVEL_W-1:0] press_level;
		logic [LEVEL_W-1:0] release_level;
		logic [LEVEL_W-1:0] press_rise;
		logic [LEVEL_W-1:0] release_fall;
		logic [LEVEL_W-1:0] hold_after_press;
		logic [LEVEL_W-1:0] hold_after_release;
	} cfg_t;

	typedef struct packed {
		logic               is_pressed;
		logic               is_armed;
		logic [LEVEL_W-1:0] peak_level;
		logic [LEVEL_W-1:0] trough_level;
		logic [LEVEL_W-1:0] hold_count;
	} trk_state_t;

endpackage

@@ hdl/rapid_trigger_key_detector_unit.sv @@
// ----------------------------------------------------------------------------
// rapid_trigger_key_detector_unit: key press/release detector, top level
// Usage:
//   Input channel (in_valid/in_ready, travel_level): one travel sample per
//   beat. Result channel (out_valid/out_ready, key_event, key_down): one
//   result per sample, in order: 0 none, 1 press, 2 release, plus the
//   pressed state after that sample.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   write only while no sample is in flight.
//   Path: a sample goes through the input register, then the result
//   register once that register is free. Throughput: one sample per
//   cycle while out_ready stays high; the tracking state updates
//   as a sample moves from the input register into the result register, so
//   the next sample sees it at once.
//   Stall: when the receiver holds out_ready low the result register holds,
//   the input register still takes one more beat, then in_ready drops.
//   Reset: settings return to their defaults (plain mode, press 128,
//   release 100, rise/fall 16, no hold), tracking state clears, both
//   registers empty.
// ----------------------------------------------------------------------------
module rapid_trigger_key_detector_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rtkd_pkg::LEVEL_W-1:0]   travel_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     key_event,
	output logic                           key_down,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rtkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rtkd_pkg::CFG_DAT_W-1:0] cfg_data
);

	rtkd_pkg::cfg_t               cfg;
	rtkd_pkg::trk_state_t         state_q;
	rtkd_pkg::trk_state_t         state_nxt;
	rtkd_pkg::key_event_t         ev;
	logic [rtkd_pkg::LEVEL_W-1:0] level_s1;
	logic                         vld_s1;
	logic [1:0]                   event_s2;
	logic                         down_s2;
	logic                         vld_s2;
	logic                         adv;

	assign cfg_ready = 1'b1;

	rtkd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	rtkd_core u_core (
		.lv  (level_s1),
		.cfg (cfg),
		.st  (state_q),
		.nxt (state_nxt),
		.ev  (ev)
	);

	// move a sample into the result register when that slot frees up
	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= travel_level;
		end
	end

	// tracking state, advanced once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			event_s2 <= ev;
			down_s2  <= state_nxt.is_pressed;
		end
	end

	assign out_valid = vld_s2;
	assign key_event = event_s2;
	assign key_down  = down_s2;

	// a press leaves the key down, a release leaves it up
	a_event_matches_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((key_event != rtkd_pkg::EV_PRESS || key_down) &&
		               (key_event != rtkd_pkg::EV_RELEASE || !key_down)))
		else $error("key_down disagrees with key_event");

	// a sample inside the rapid-mode hold window gives no event
	a_hold_mutes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cfg.rapid_mode && state_q.hold_count != '0) |=>
		(out_valid && key_event == rtkd_pkg::EV_NONE))
		else $error("event reported during hold window");

	// plain mode leaves the rapid tracking fields alone
	a_plain_keeps_track: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !cfg.rapid_mode) |=>
		($stable(state_q.hold_count) && $stable(state_q.is_armed) &&
		 $stable(state_q.peak_level) && $stable(state_q.trough_level)))
		else $error("plain mode changed rapid tracking state");

endmodule

@@ hdl/rtkd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rtkd_cfg_regs: configuration register file
// Holds the eight detector settings; one write beat per cycle, always ready.
// ----------------------------------------------------------------------------
module rtkd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rtkd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [rtkd_pkg::CFG_DAT_W-1:0] wr_data,
	output rtkd_pkg::cfg_t                 cfg
);

	rtkd_pkg::cfg_t cfg_q;

	// update the addressed register on a write beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rapid_mode         <= 1'b0;
			cfg_q.continuous_mode    <= 1'b0;
			cfg_q.press_level        <= rtkd_pkg::RST_PRESS_LEVEL;
			cfg_q.release_level      <= rtkd_pkg::RST_RELEASE_LEVEL;
			cfg_q.press_rise         <= rtkd_pkg::RST_PRESS_RISE;
			cfg_q.release_fall       <= rtkd_pkg::RST_RELEASE_FALL;
			cfg_q.hold_after_press   <= rtkd_pkg::RST_HOLD;
			cfg_q.hold_after_release <= rtkd_pkg::RST_HOLD;
		end else if (wr_en) begin
			case (wr_index)
				rtkd_pkg::REG_RAPID_MODE:      cfg_q.rapid_mode         <= wr_data[0];
				rtkd_pkg::REG_CONTINUOUS_MODE: cfg_q.continuous_mode    <= wr_data[0];
				rtkd_pkg::REG_PRESS_LEVEL:     cfg_q.press_level        <= wr_data;
				rtkd_pkg::REG_RELEASE_LEVEL:   cfg_q.release_level      <= wr_data;
				rtkd_pkg::REG_PRESS_RISE:      cfg_q.press_rise         <= wr_data;
				rtkd_pkg::REG_RELEASE_FALL:    cfg_q.release_fall       <= wr_data;
				rtkd_pkg::REG_HOLD_PRESS:      cfg_q.hold_after_press   <= wr_data;
				rtkd_pkg::REG_HOLD_RELEASE:    cfg_q.hold_after_release <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/rtkd_core.sv @@
// ----------------------------------------------------------------------------
// rtkd_core: per-sample decision logic
// Given one travel level, the settings and the tracking state, produce the
// event and the next tracking state (plain thresholds or rapid tracking).
// ----------------------------------------------------------------------------
module rtkd_core (
	input  logic [rtkd_pkg::LEVEL_W-1:0] lv,
	input  rtkd_pkg::cfg_t               cfg,
	input  rtkd_pkg::trk_state_t         st,
	output rtkd_pkg::trk_state_t         nxt,
	output rtkd_pkg::key_event_t         ev
);

	logic [rtkd_pkg::LEVEL_W-1:0] rise_diff;
	logic [rtkd_pkg::LEVEL_W-1:0] fall_diff;
	logic                         release_hit;

	// distances from the running trough and peak
	assign rise_diff   = lv - st.trough_level;
	assign fall_diff   = st.peak_level - lv;
	assign release_hit = (lv == rtkd_pkg::ZERO_TRAVEL) ||
	                     ((lv < cfg.release_level) && !cfg.continuous_mode);

	// decide the event and the next state
	always_comb begin
		nxt = st;
		ev  = rtkd_pkg::EV_NONE;
		if (!cfg.rapid_mode) begin
			if (!st.is_pressed && (lv > cfg.press_level)) begin
				nxt.is_pressed = 1'b1;
				ev             = rtkd_pkg::EV_PRESS;
			end else if (st.is_pressed && (lv < cfg.release_level)) begin
				nxt.is_pressed = 1'b0;
				ev             = rtkd_pkg::EV_RELEASE;
			end
		end else if (st.hold_count != '0) begin
			// count down the hold window, no event
			nxt.hold_count = st.hold_count - 1'b1;
		end else if (!st.is_pressed && !st.is_armed) begin
			// first press arms the key
			if (lv > cfg.press_level) begin
				nxt.is_armed   = 1'b1;
				nxt.is_pressed = 1'b1;
				nxt.peak_level = lv;
				nxt.hold_count = cfg.hold_after_press;
				ev             = rtkd_pkg::EV_PRESS;
			end
		end else if (release_hit) begin
			// disarm, and release if still down
			nxt.is_armed     = 1'b0;
			nxt.trough_level = lv;
			if (st.is_pressed) begin
				nxt.is_pressed = 1'b0;
				nxt.hold_count = cfg.hold_after_release;
				ev             = rtkd_pkg::EV_RELEASE;
			end
		end else if (!st.is_pressed) begin
			// armed and up: follow the trough, re-press on a rise
			if (lv < st.trough_level) begin
				nxt.trough_level = lv;
			end else if ((lv > st.trough_level) &&
			             ((lv == rtkd_pkg::FULL_TRAVEL) || (rise_diff >= cfg.press_rise))) begin
				nxt.peak_level = lv;
				nxt.is_pressed = 1'b1;
				nxt.hold_count = cfg.hold_after_press;
				ev             = rtkd_pkg::EV_PRESS;
			end
		end else begin
			// down: follow the peak, release on a fall
			if (lv > st.peak_level) begin
				nxt.peak_level = lv;
			end else if ((lv < st.peak_level) && (fall_diff >= cfg.release_fall)) begin
				nxt.trough_level = lv;
				nxt.is_pressed   = 1'b0;
				nxt.hold_count   = cfg.hold_after_release;
				ev               = rtkd_pkg::EV_RELEASE;
			end
		end
	end

endmodule

@@ tb/rtkd_key_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtkd_key_checker: result checker for the rapid trigger key detector
// Watches the register, sample and result channels. Tracks the detector's
// settings and key state on every accepted beat, predicts the event and
// pressed flag of each sample, and compares the result beats in order.
// ----------------------------------------------------------------------------
module rtkd_key_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [rtkd_pkg::LEVEL_W-1:0]   travel_level,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [1:0]                     key_event,
	input  logic                           key_down,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rtkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rtkd_pkg::CFG_DAT_W-1:0] cfg_data,
	output int unsigned                    mismatches,
	output int unsigned                    pending,
	output int unsigned                    events_seen
);

	localparam int unsigned REPORT_CAP = 200;

	typedef struct {
		rtkd_pkg::key_event_t ev;
		logic                 down;
	} key_result_t;

	rtkd_pkg::cfg_t       settings;
	rtkd_pkg::trk_state_t key_st;
	key_result_t          results_due[$];
	int unsigned          err_cnt = 0;
	int unsigned          ev_cnt  = 0;

	// plain thresholds with hysteresis; only the pressed flag of the tracking state changes
	function automatic rtkd_pkg::key_event_t plain_scan(
		input logic [rtkd_pkg::LEVEL_W-1:0] lv);
		if (!key_st.is_pressed && lv > settings.press_level) begin
			key_st.is_pressed = 1'b1;
			return rtkd_pkg::EV_PRESS;
		end
		if (key_st.is_pressed && lv < settings.release_level) begin
			key_st.is_pressed = 1'b0;
			return rtkd_pkg::EV_RELEASE;
		end
		return rtkd_pkg::EV_NONE;
	endfunction

	// rapid trigger: arm on first press, then follow peak and trough
	function automatic rtkd_pkg::key_event_t rapid_scan(
		input logic [rtkd_pkg::LEVEL_W-1:0] lv);
		if (key_st.hold_count != '0) begin
			key_st.hold_count = key_st.hold_count - 1'b1;
			return rtkd_pkg::EV_NONE;
		end
		if (!key_st.is_pressed && !key_st.is_armed) begin
			if (lv <= settings.press_level)
				return rtkd_pkg::EV_NONE;
			key_st.is_armed   = 1'b1;
			key_st.is_pressed = 1'b1;
			key_st.peak_level = lv;
			key_st.hold_count = settings.hold_after_press;
			return rtkd_pkg::EV_PRESS;
		end
		// full release: zero always disarms, the threshold only without continuous
		if (lv == rtkd_pkg::ZERO_TRAVEL ||
		    (lv < settings.release_level && !settings.continuous_mode)) begin
			key_st.is_armed     = 1'b0;
			key_st.trough_level = lv;
			if (!key_st.is_pressed)
				return rtkd_pkg::EV_NONE;
			key_st.is_pressed = 1'b0;
			key_st.hold_count = settings.hold_after_release;
			return rtkd_pkg::EV_RELEASE;
		end
		// released but armed: follow the trough, re-press on a rise
		if (!key_st.is_pressed) begin
			if (lv < key_st.trough_level) begin
				key_st.trough_level = lv;
				return rtkd_pkg::EV_NONE;
			end
			if (lv == key_st.trough_level)
				return rtkd_pkg::EV_NONE;
			if (lv != rtkd_pkg::FULL_TRAVEL &&
			    (lv - key_st.trough_level) < settings.press_rise)
				return rtkd_pkg::EV_NONE;
			key_st.peak_level = lv;
			key_st.is_pressed = 1'b1;
			key_st.hold_count = settings.hold_after_press;
			return rtkd_pkg::EV_PRESS;
		end
		// pressed: follow the peak, release on a fall
		if (lv > key_st.peak_level) begin
			key_st.peak_level = lv;
			return rtkd_pkg::EV_NONE;
		end
		if (lv == key_st.peak_level)
			return rtkd_pkg::EV_NONE;
		if ((key_st.peak_level - lv) < settings.release_fall)
			return rtkd_pkg::EV_NONE;
		key_st.trough_level = lv;
		key_st.is_pressed   = 1'b0;
		key_st.hold_count   = settings.hold_after_release;
		return rtkd_pkg::EV_RELEASE;
	endfunction

	always @(posedge clk) begin
		key_result_t due;
		key_result_t got;
		if (!arst_n) begin
			settings = '{
				rapid_mode:         1'b0,
				continuous_mode:    1'b0,
				press_level:        rtkd_pkg::RST_PRESS_LEVEL,
				release_level:      rtkd_pkg::RST_RELEASE_LEVEL,
				press_rise:         rtkd_pkg::RST_PRESS_RISE,
				release_fall:       rtkd_pkg::RST_RELEASE_FALL,
				hold_after_press:   rtkd_pkg::RST_HOLD,
				hold_after_release: rtkd_pkg::RST_HOLD
			};
			key_st = '0;
			results_due.delete();
		end else begin
			// compare a result beat against the oldest prediction
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_CAP)
						$error("unexpected result beat: key_event=%0d key_down=%0d",
							key_event, key_down);
				end else begin
					due = results_due.pop_front();
					if (key_event !== due.ev) begin
						err_cnt++;
						if (err_cnt <= REPORT_CAP)
							$error("key_event mismatch: expected %0d, actual %0d",
								due.ev, key_event);
					end
					if (key_down !== due.down) begin
						err_cnt++;
						if (err_cnt <= REPORT_CAP)
							$error("key_down mismatch: expected %0d, actual %0d",
								due.down, key_down);
					end
					if (due.ev != rtkd_pkg::EV_NONE)
						ev_cnt++;
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rtkd_pkg::REG_RAPID_MODE:
						settings.rapid_mode = cfg_data[0];
					rtkd_pkg::REG_CONTINUOUS_MODE:
						settings.continuous_mode = cfg_data[0];
					rtkd_pkg::REG_PRESS_LEVEL:
						settings.press_level = cfg_data;
					rtkd_pkg::REG_RELEASE_LEVEL:
						settings.release_level = cfg_data;
					rtkd_pkg::REG_PRESS_RISE:
						settings.press_rise = cfg_data;
					rtkd_pkg::REG_RELEASE_FALL:
						settings.release_fall = cfg_data;
					rtkd_pkg::REG_HOLD_PRESS:
						settings.hold_after_press = cfg_data;
					rtkd_pkg::REG_HOLD_RELEASE:
						settings.hold_after_release = cfg_data;
					default: ;
				endcase
			end
			// predict the result of a sample beat
			if (in_valid && in_ready) begin
				got.ev   = settings.rapid_mode ? rapid_scan(travel_level)
					: plain_scan(travel_level);
				got.down = key_st.is_pressed;
				results_due.push_back(got);
			end
		end
		mismatches  <= err_cnt;
		pending     <= results_due.size();
		events_seen <= ev_cnt;
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the rapid trigger key detector
// Runs short directed travel sequences in plain, rapid and continuous
// modes, then random settings with key stroke sequences and noise, with
// random gaps on the sample channel and stalls on the result channel.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned SAMPLE_TARGET = 1850;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	typedef logic [rtkd_pkg::LEVEL_W-1:0] level_q_t[$];

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [rtkd_pkg::LEVEL_W-1:0]   travel_level;
	logic                           out_valid;
	logic                           out_ready;
	logic [1:0]                     key_event;
	logic                           key_down;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [rtkd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rtkd_pkg::CFG_DAT_W-1:0] cfg_data;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned events_seen;
	int unsigned samples_sent  = 0;
	int unsigned reg_writes    = 0;
	int unsigned settings_used = 0;
	int unsigned cycles        = 0;
	logic        calm;

	rapid_trigger_key_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.travel_level (travel_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_event    (key_event),
		.key_down     (key_down),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rtkd_key_checker key_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.travel_level (travel_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_event    (key_event),
		.key_down     (key_down),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.events_seen  (events_seen)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// stall the result channel at random outside calm stretches
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 8);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one sample beat, with a random gap ahead of it
	task automatic send_level(input logic [rtkd_pkg::LEVEL_W-1:0] lv);
		while (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		travel_level <= lv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic feed_levels(input level_q_t seq);
		foreach (seq[i])
			send_level(seq[i]);
	endtask

	// mostly key strokes walking toward random targets, some noise; all noise when noise_only is set
	task automatic feed_strokes(input int unsigned n, input bit noise_only);
		int lvl;
		int aim;
		int stride;
		lvl = $urandom_range(0, 255);
		aim = lvl;
		for (int unsigned k = 0; k < n; k++) begin
			if (noise_only || $urandom_range(0, 9) == 0) begin
				send_level(rtkd_pkg::LEVEL_W'($urandom_range(0, 255)));
			end else begin
				if (lvl == aim) begin
					case ($urandom_range(0, 3))
						0: aim = 0;
						1: aim = 255;
						default: aim = $urandom_range(0, 255);
					endcase
				end
				stride = $urandom_range(1, 24);
				if (aim > lvl)
					lvl = (lvl + stride > aim) ? aim : lvl + stride;
				else
					lvl = (lvl - stride < aim) ? aim : lvl - stride;
				send_level(rtkd_pkg::LEVEL_W'(lvl));
			end
		end
	endtask

	// hold valid until the register beat is taken; caller drops valid
	task automatic write_reg(input logic [rtkd_pkg::CFG_IDX_W-1:0] idx,
		input logic [rtkd_pkg::CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes++;
	endtask

	task automatic load_settings(input rtkd_pkg::cfg_t c);
		write_reg(rtkd_pkg::REG_RAPID_MODE, rtkd_pkg::CFG_DAT_W'(c.rapid_mode));
		write_reg(rtkd_pkg::REG_CONTINUOUS_MODE, rtkd_pkg::CFG_DAT_W'(c.continuous_mode));
		write_reg(rtkd_pkg::REG_PRESS_LEVEL, c.press_level);
		write_reg(rtkd_pkg::REG_RELEASE_LEVEL, c.release_level);
		write_reg(rtkd_pkg::REG_PRESS_RISE, c.press_rise);
		write_reg(rtkd_pkg::REG_RELEASE_FALL, c.release_fall);
		write_reg(rtkd_pkg::REG_HOLD_PRESS, c.hold_after_press);
		write_reg(rtkd_pkg::REG_HOLD_RELEASE, c.hold_after_release);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// drop valid and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [rtkd_pkg::LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return rtkd_pkg::ZERO_TRAVEL;
			1: return rtkd_pkg::FULL_TRAVEL;
			default: return rtkd_pkg::LEVEL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [rtkd_pkg::LEVEL_W-1:0] pick_delta();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return rtkd_pkg::LEVEL_W'($urandom_range(0, 255));
			default: return rtkd_pkg::LEVEL_W'($urandom_range(1, 48));
		endcase
	endfunction

	function automatic logic [rtkd_pkg::LEVEL_W-1:0] pick_hold();
		case ($urandom_range(0, 19))
			0: return 8'd255;
			1, 2, 3, 4, 5, 6: return rtkd_pkg::LEVEL_W'($urandom_range(1, 4));
			default: return 8'd0;
		endcase
	endfunction

	function automatic rtkd_pkg::cfg_t random_settings();
		rtkd_pkg::cfg_t c;
		c.rapid_mode         = ($urandom_range(0, 9) < 7);
		c.continuous_mode    = 1'($urandom_range(0, 1));
		c.press_level        = pick_level();
		c.release_level      = pick_level();
		c.press_rise         = pick_delta();
		c.release_fall       = pick_delta();
		c.hold_after_press   = pick_hold();
		c.hold_after_release = pick_hold();
		return c;
	endfunction

	initial begin
		rtkd_pkg::cfg_t c;
		level_q_t       seq;
		int unsigned    phase;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		travel_level = '0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		calm         = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain mode at reset settings: threshold edges and hysteresis
		seq = '{8'd128, 8'd129, 8'd100, 8'd99, 8'd255, 8'd0};
		feed_levels(seq);
		drain();

		// rapid mode: arm, peak fall by the delta, trough rise, zero disarm
		c = '{
			rapid_mode:         1'b1,
			continuous_mode:    1'b0,
			press_level:        rtkd_pkg::RST_PRESS_LEVEL,
			release_level:      rtkd_pkg::RST_RELEASE_LEVEL,
			press_rise:         rtkd_pkg::RST_PRESS_RISE,
			release_fall:       rtkd_pkg::RST_RELEASE_FALL,
			hold_after_press:   rtkd_pkg::RST_HOLD,
			hold_after_release: rtkd_pkg::RST_HOLD
		};
		load_settings(c);
		seq = '{8'd200, 8'd210, 8'd195, 8'd194, 8'd180, 8'd196, 8'd0, 8'd150};
		feed_levels(seq);
		drain();

		// continuous mode with holds, zero fall delta and full travel re-press
		c.continuous_mode    = 1'b1;
		c.release_level      = 8'd255;
		c.press_rise         = 8'd255;
		c.release_fall       = 8'd0;
		c.hold_after_press   = 8'd2;
		c.hold_after_release = 8'd1;
		c.rapid_mode         = 1'b0;
		load_settings(c);
		seq = '{8'd90};
		feed_levels(seq);
		drain();
		c.rapid_mode = 1'b1;
		load_settings(c);
		seq = '{8'd130, 8'd10, 8'd10, 8'd140, 8'd140, 8'd139, 8'd100, 8'd101,
			8'd254, 8'd255, 8'd0, 8'd0, 8'd0};
		feed_levels(seq);
		drain();

		// random settings, strokes and noise; a calm stretch in the middle
		phase = 0;
		while (samples_sent < SAMPLE_TARGET) begin
			calm <= (phase >= 6 && phase < 12);
			load_settings(random_settings());
			feed_strokes($urandom_range(20, 80), $urandom_range(0, 4) == 0);
			drain();
			phase++;
		end

		$display("Summary: %0d travel samples over %0d register settings (%0d writes)",
			samples_sent, settings_used, reg_writes);
		$display("Summary: %0d press and release events matched", events_seen);
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ rapid_trigger_key_detector_unit.f @@
hdl/rtkd_pkg.sv
hdl/rtkd_cfg_regs.sv
hdl/rtkd_core.sv
hdl/rapid_trigger_key_detector_unit.sv
tb/rtkd_key_checker.sv
tb/testbench.sv
